### rtl/sacf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the servo ASCII command framer.
// No dependencies; imported by sacf_prep, sacf_cell, the core, the checker and the testbench.
package sacf_pkg;

  // Longest frame: '#', three id digits, P, four digits, T or B, four digits, '!'.
  localparam int unsigned FrameLen = 15;
  localparam int unsigned LenW     = $clog2(FrameLen + 1);

  typedef enum logic [2:0] {
    REQ_OPEN    = 3'd0,
    REQ_CLOSED  = 3'd1,
    REQ_SPEED   = 3'd2,
    REQ_SET_ID  = 3'd3,
    REQ_READ_ID = 3'd4,
    REQ_VERSION = 3'd5,
    REQ_BAUD    = 3'd6,
    REQ_DEBUG   = 3'd7
  } req_kind_e;

  typedef logic [3:0] digit_t;

  // Everything the frame builder needs, already split into decimal digits.
  typedef struct packed {
    req_kind_e       kind;
    logic [3:0]      baud;
    digit_t [2:0]    id_dig;
    digit_t [3:0]    p_dig;
    digit_t [3:0]    t_dig;
    digit_t [2:0]    nid_dig;
  } prep_t;

  // One position of the output shift chain.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } cell_t;

endpackage

### rtl/sacf_req_if.sv
`timescale 1ns / 1ps
// Request channel: one motor command per beat.
// Depends on nothing.
interface sacf_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [7:0]         motor_id;
  logic [13:0]        pwm_value;
  logic [15:0]        time_value;
  logic signed [15:0] lin_speed;
  logic [7:0]         new_id;
  logic [3:0]         baud_sel;

  modport source (
    output valid, req_type, motor_id, pwm_value, time_value, lin_speed, new_id, baud_sel,
    input  ready
  );
  modport sink (
    input  valid, req_type, motor_id, pwm_value, time_value, lin_speed, new_id, baud_sel,
    output ready
  );
endinterface

### rtl/sacf_byte_if.sv
`timescale 1ns / 1ps
// Byte channel: one ASCII frame byte per beat, last_byte on the closing '!'.
// Depends on nothing.
interface sacf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

### rtl/sacf_prep.sv
`timescale 1ns / 1ps
// Six-stage request pipeline: saturation, speed-to-pwm, ms-to-s, decimal digits.
// Depends on sacf_pkg and sacf_req_if.
module sacf_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  sacf_req_if.sink       req_i,
  output logic           prep_valid_o,
  input  logic           prep_ready_i,
  output sacf_pkg::prep_t prep_o
);
  import sacf_pkg::*;

  localparam int unsigned NumStages = 6;

  localparam logic [13:0]        PrintMax    = 14'd9999;
  localparam logic [13:0]        PwmMin      = 14'd1475;
  localparam int                 PwmHalfSpan = 25;
  localparam int                 SpdDiv      = 3224;
  localparam int                 MsPerSec    = 1000;
  // Speeds beyond these already sit on the pwm clamp.
  localparam logic signed [15:0] SpdHi       = 16'sd806;
  localparam logic signed [15:0] SpdLo       = -16'sd806;
  localparam logic signed [18:0] SpdScale    = 19'sd100;
  localparam logic signed [18:0] SpdBias     = 19'(SpdDiv * PwmHalfSpan);
  localparam logic [13:0]        W1000       = 14'd1000;
  localparam logic [13:0]        W100        = 14'd100;
  localparam logic [13:0]        W10         = 14'd10;

  typedef struct packed {
    req_kind_e          kind;
    logic [7:0]         id;
    logic [13:0]        pwm;
    logic [15:0]        tim;
    logic signed [15:0] spd;
    logic [7:0]         nid;
    logic [3:0]         baud;
  } s0_t;

  typedef struct packed {
    req_kind_e   kind;
    logic [7:0]  id;
    logic [7:0]  nid;
    logic [3:0]  baud;
    logic [13:0] pwm_sat;
    logic [15:0] tim;
    logic [13:0] tim_sat;
    logic [17:0] u;
  } s1_t;

  typedef struct packed {
    prep_t       f;
    logic [13:0] rp;
    logic [13:0] rt;
    logic [13:0] rid;
    logic [13:0] rnid;
  } dstage_t;

  typedef struct packed {
    digit_t      digit;
    logic [13:0] rest;
  } peel_t;

  // Take one decimal digit of weight w off v, four compare-subtract steps.
  function automatic peel_t peel(input logic [13:0] v, input logic [13:0] w);
    peel_t       r;
    logic [13:0] ws;
    r.rest  = v;
    r.digit = '0;
    for (int b = 3; b >= 0; b--) begin
      ws = w << b;
      if (r.rest >= ws) begin
        r.rest     = r.rest - ws;
        r.digit[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Restoring quotient by the speed divisor; the result never exceeds 50.
  function automatic logic [5:0] div_speed(input logic [17:0] u);
    logic [17:0] rem;
    logic [17:0] ds;
    logic [5:0]  q;
    rem = u;
    q   = '0;
    for (int b = 5; b >= 0; b--) begin
      ds = 18'(SpdDiv) << b;
      if (rem >= ds) begin
        rem  = rem - ds;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Restoring quotient by 1000 over a 16-bit time.
  function automatic logic [6:0] div_ms(input logic [15:0] t);
    logic [15:0] rem;
    logic [15:0] ds;
    logic [6:0]  q;
    rem = t;
    q   = '0;
    for (int b = 6; b >= 0; b--) begin
      ds = 16'(MsPerSec) << b;
      if (rem >= ds) begin
        rem  = rem - ds;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  logic [NumStages-1:0] vld_q, vld_d, rdy;

  s0_t     s0_q;
  s1_t     s1_q, s1_d;
  dstage_t s2_q, s2_d, s3_q, s3_d, s4_q, s4_d, s5_q, s5_d;

  logic signed [15:0] spd_c;
  logic signed [18:0] spd_prod;
  peel_t pk3_p, pk3_t, pk3_id, pk3_nid;
  peel_t pk4_p, pk4_t, pk4_id, pk4_nid;
  peel_t pk5_p, pk5_t;

  // Handshake: a stage takes new data when empty or when it drains this cycle.
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || prep_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? req_i.valid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign req_i.ready  = rdy[0];
  assign prep_valid_o = vld_q[NumStages-1];
  assign prep_o       = s5_q.f;

  // Stage 1: saturate printed values, scale and offset the clamped speed.
  always_comb begin
    if (s0_q.spd > SpdHi) begin
      spd_c = SpdHi;
    end else if (s0_q.spd < SpdLo) begin
      spd_c = SpdLo;
    end else begin
      spd_c = s0_q.spd;
    end
    spd_prod     = 19'(spd_c) * SpdScale + SpdBias;
    s1_d.kind    = s0_q.kind;
    s1_d.id      = s0_q.id;
    s1_d.nid     = s0_q.nid;
    s1_d.baud    = s0_q.baud;
    s1_d.pwm_sat = (s0_q.pwm > PrintMax) ? PrintMax : s0_q.pwm;
    s1_d.tim     = s0_q.tim;
    s1_d.tim_sat = (s0_q.tim > 16'(PrintMax)) ? PrintMax : s0_q.tim[13:0];
    s1_d.u       = spd_prod[17:0];
  end

  // Stage 2: pick the two four-digit values.
  always_comb begin
    s2_d        = '0;
    s2_d.f.kind = s1_q.kind;
    s2_d.f.baud = s1_q.baud;
    if (s1_q.kind == REQ_SPEED) begin
      s2_d.rp = PwmMin + 14'(div_speed(s1_q.u));
      s2_d.rt = 14'(div_ms(s1_q.tim));
    end else begin
      s2_d.rp = s1_q.pwm_sat;
      s2_d.rt = s1_q.tim_sat;
    end
    s2_d.rid  = 14'(s1_q.id);
    s2_d.rnid = 14'(s1_q.nid);
  end

  // Stages 3 to 5: peel one digit per stage.
  always_comb begin
    pk3_p   = peel(s2_q.rp, W1000);
    pk3_t   = peel(s2_q.rt, W1000);
    pk3_id  = peel(s2_q.rid, W100);
    pk3_nid = peel(s2_q.rnid, W100);
    s3_d              = s2_q;
    s3_d.f.p_dig[3]   = pk3_p.digit;
    s3_d.f.t_dig[3]   = pk3_t.digit;
    s3_d.f.id_dig[2]  = pk3_id.digit;
    s3_d.f.nid_dig[2] = pk3_nid.digit;
    s3_d.rp           = pk3_p.rest;
    s3_d.rt           = pk3_t.rest;
    s3_d.rid          = pk3_id.rest;
    s3_d.rnid         = pk3_nid.rest;
  end

  always_comb begin
    pk4_p   = peel(s3_q.rp, W100);
    pk4_t   = peel(s3_q.rt, W100);
    pk4_id  = peel(s3_q.rid, W10);
    pk4_nid = peel(s3_q.rnid, W10);
    s4_d              = s3_q;
    s4_d.f.p_dig[2]   = pk4_p.digit;
    s4_d.f.t_dig[2]   = pk4_t.digit;
    s4_d.f.id_dig[1]  = pk4_id.digit;
    s4_d.f.id_dig[0]  = pk4_id.rest[3:0];
    s4_d.f.nid_dig[1] = pk4_nid.digit;
    s4_d.f.nid_dig[0] = pk4_nid.rest[3:0];
    s4_d.rp           = pk4_p.rest;
    s4_d.rt           = pk4_t.rest;
  end

  always_comb begin
    pk5_p = peel(s4_q.rp, W10);
    pk5_t = peel(s4_q.rt, W10);
    s5_d            = s4_q;
    s5_d.f.p_dig[1] = pk5_p.digit;
    s5_d.f.p_dig[0] = pk5_p.rest[3:0];
    s5_d.f.t_dig[1] = pk5_t.digit;
    s5_d.f.t_dig[0] = pk5_t.rest[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_q.kind <= req_kind_e'(req_i.req_type);
      s0_q.id   <= req_i.motor_id;
      s0_q.pwm  <= req_i.pwm_value;
      s0_q.tim  <= req_i.time_value;
      s0_q.spd  <= req_i.lin_speed;
      s0_q.nid  <= req_i.new_id;
      s0_q.baud <= req_i.baud_sel;
    end
    if (rdy[1]) begin
      s1_q <= s1_d;
    end
    if (rdy[2]) begin
      s2_q <= s2_d;
    end
    if (rdy[3]) begin
      s3_q <= s3_d;
    end
    if (rdy[4]) begin
      s4_q <= s4_d;
    end
    if (rdy[5]) begin
      s5_q <= s5_d;
    end
  end

endmodule

### rtl/sacf_cell.sv
`timescale 1ns / 1ps
// One byte position of the output shift chain.
// Depends on sacf_pkg.
module sacf_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            load_i,
  input  sacf_pkg::cell_t load_cell_i,
  input  sacf_pkg::cell_t next_cell_i,
  output sacf_pkg::cell_t cell_o
);
  import sacf_pkg::*;

  cell_t cell_q, cell_d;

  // Load a fresh frame byte, else take the neighbor's byte, else hold.
  always_comb begin
    priority if (load_i) begin
      cell_d = load_cell_i;
    end else if (shift_i) begin
      cell_d = next_cell_i;
    end else begin
      cell_d = cell_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/servo_ascii_command_framer_core.sv
`timescale 1ns / 1ps
// Top level of the servo ASCII command framer: request pipeline plus byte shift chain.
// Depends on sacf_pkg, sacf_req_if, sacf_byte_if, sacf_prep and sacf_cell.
//
//   channel | dir | beat
//   --------+-----+------------------------------------------------------------
//   req_i   | in  | one command: type, id, pwm, time, speed, new id, baud index
//   tx_o    | out | one frame byte, last_byte set on the closing '!'
//
// A frame is 8 to 15 bytes and leaves at one byte per cycle while tx_o is
// ready; the fifteen-cell shift chain loads a whole frame at once.
// The request passes the six pipeline stages and the chain load before its first
// byte appears. rst_ni clears all valid flags asynchronously.
// A stall on tx_o holds the chain, then the pipeline, then req_i.ready.
module servo_ascii_command_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacf_req_if.sink   req_i,
  sacf_byte_if.source tx_o
);
  import sacf_pkg::*;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChUpD   = 8'h44;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChUpI   = 8'h49;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] ChUpR   = 8'h52;
  localparam logic [7:0] ChUpT   = 8'h54;
  localparam logic [7:0] ChUpV   = 8'h56;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChLowG  = 8'h67;
  localparam logic [7:0] ChLowU  = 8'h75;

  localparam logic [3:0] BaudTwoDigit = 4'd10;

  localparam logic [LenW-1:0] LenTimed   = LenW'(15);
  localparam logic [LenW-1:0] LenSetId   = LenW'(11);
  localparam logic [LenW-1:0] LenReadId  = LenW'(8);
  localparam logic [LenW-1:0] LenVersion = LenW'(9);
  localparam logic [LenW-1:0] LenBaud1   = LenW'(9);
  localparam logic [LenW-1:0] LenBaud2   = LenW'(10);
  localparam logic [LenW-1:0] LenDebug   = LenW'(11);

  function automatic logic [7:0] asc(input digit_t d);
    return ChZero | {4'h0, d};
  endfunction

  logic  prep_valid, prep_ready;
  prep_t prep;

  logic shift, load;
  logic [FrameLen-1:0][7:0] fb;
  logic [LenW-1:0]          len;
  cell_t load_cell [FrameLen];
  cell_t cell_q    [FrameLen];

  // Decode the request and split its numbers into digits.
  sacf_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .prep_valid_o (prep_valid),
    .prep_ready_i (prep_ready),
    .prep_o       (prep)
  );

  // Frame body, left aligned. The closing '!' is placed at len-1 below.
  always_comb begin
    fb    = '0;
    fb[0] = ChHash;
    fb[1] = asc(prep.id_dig[2]);
    fb[2] = asc(prep.id_dig[1]);
    fb[3] = asc(prep.id_dig[0]);
    fb[4] = ChUpP;
    unique case (prep.kind)
      REQ_OPEN, REQ_CLOSED, REQ_SPEED: begin
        fb[5]  = asc(prep.p_dig[3]);
        fb[6]  = asc(prep.p_dig[2]);
        fb[7]  = asc(prep.p_dig[1]);
        fb[8]  = asc(prep.p_dig[0]);
        fb[9]  = (prep.kind == REQ_OPEN) ? ChUpT : ChUpB;
        fb[10] = asc(prep.t_dig[3]);
        fb[11] = asc(prep.t_dig[2]);
        fb[12] = asc(prep.t_dig[1]);
        fb[13] = asc(prep.t_dig[0]);
        len    = LenTimed;
      end
      REQ_SET_ID: begin
        fb[5] = ChUpI;
        fb[6] = ChUpD;
        fb[7] = asc(prep.nid_dig[2]);
        fb[8] = asc(prep.nid_dig[1]);
        fb[9] = asc(prep.nid_dig[0]);
        len   = LenSetId;
      end
      REQ_READ_ID: begin
        fb[5] = ChUpI;
        fb[6] = ChUpD;
        len   = LenReadId;
      end
      REQ_VERSION: begin
        fb[5] = ChUpV;
        fb[6] = ChUpE;
        fb[7] = ChUpR;
        len   = LenVersion;
      end
      REQ_BAUD: begin
        fb[5] = ChUpB;
        fb[6] = ChUpD;
        // Indexes ten and up print as two digits.
        if (prep.baud >= BaudTwoDigit) begin
          fb[7] = ChOne;
          fb[8] = asc(prep.baud - BaudTwoDigit);
          len   = LenBaud2;
        end else begin
          fb[7] = asc(prep.baud);
          len   = LenBaud1;
        end
      end
      REQ_DEBUG: begin
        fb[5]  = ChUpD;
        fb[6]  = ChLowE;
        fb[7]  = ChLowB;
        fb[8]  = ChLowU;
        fb[9]  = ChLowG;
        len    = LenDebug;
      end
      default: begin
        len = LenTimed;
      end
    endcase
  end

  // Advance the chain whenever the head byte leaves or the head is empty.
  // Load the next frame when the chain advances with at most the head byte left in it.
  assign shift      = !cell_q[0].valid || tx_o.ready;
  assign prep_ready = shift && !cell_q[1].valid;
  assign load       = prep_valid && prep_ready;

  for (genvar k = 0; k < FrameLen; k++) begin : g_cell
    always_comb begin
      load_cell[k].valid = LenW'(k) < len;
      load_cell[k].last  = LenW'(k) == len - LenW'(1);
      load_cell[k].data  = load_cell[k].last ? ChBang : fb[k];
    end

    if (k == FrameLen - 1) begin : g_tail
      sacf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .load_i      (load),
        .load_cell_i (load_cell[k]),
        .next_cell_i ('0),
        .cell_o      (cell_q[k])
      );
    end else begin : g_body
      sacf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .load_i      (load),
        .load_cell_i (load_cell[k]),
        .next_cell_i (cell_q[k+1]),
        .cell_o      (cell_q[k])
      );
    end
  end

  // Head cell drives the byte channel directly.
  assign tx_o.valid     = cell_q[0].valid;
  assign tx_o.tx_byte   = cell_q[0].data;
  assign tx_o.last_byte = cell_q[0].last;

endmodule

### sim/servo_ascii_command_framer_core_checker.sv
`timescale 1ns / 1ps
// Checker for servo_ascii_command_framer_core: watches both channels, builds the
// expected ASCII frame of every accepted request and compares each byte beat.
// Depends on sacf_pkg, sacf_req_if and sacf_byte_if.
module servo_ascii_command_framer_core_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  sacf_req_if   req_i,
  sacf_byte_if  tx_i,
  output int    fail_cnt_o,
  output int    open_bytes_o,
  output int    frame_cnt_o,
  output int    byte_cnt_o
);
  import sacf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_q[$];

  function automatic void put_char(logic [7:0] c);
    frame_q.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // Zero-padded decimal, most significant digit first.
  function automatic void put_dec(int unsigned v, int unsigned width);
    int unsigned div;
    div = 1;
    for (int unsigned i = 1; i < width; i++) div *= 10;
    while (div > 0) begin
      put_char(8'h30 + 8'((v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic int unsigned clamp_9999(int unsigned v);
    return (v > 9999) ? 9999 : v;
  endfunction

  // Floor of speed*100/3224 around 1500, held to the 1475..1525 window.
  function automatic int unsigned speed_to_pulse(logic signed [15:0] spd);
    int num;
    int q;
    int p;
    num = int'(spd) * 100;
    q   = num / 3224;
    if (num < 0 && (num % 3224) != 0) q--;
    p = 1500 + q;
    if (p > 1525) p = 1525;
    if (p < 1475) p = 1475;
    return p;
  endfunction

  function automatic void queue_frame(req_kind_e kind, logic [7:0] id, logic [13:0] pwm,
                                      logic [15:0] tim, logic signed [15:0] spd,
                                      logic [7:0] nid, logic [3:0] baud);
    put_char("#");
    put_dec(id, 3);
    case (kind)
      REQ_OPEN: begin
        put_char("P"); put_dec(clamp_9999(pwm), 4);
        put_char("T"); put_dec(clamp_9999(tim), 4);
      end
      REQ_CLOSED: begin
        put_char("P"); put_dec(clamp_9999(pwm), 4);
        put_char("B"); put_dec(clamp_9999(tim), 4);
      end
      REQ_SPEED: begin
        put_char("P"); put_dec(speed_to_pulse(spd), 4);
        put_char("B"); put_dec(tim / 1000, 4);
      end
      REQ_SET_ID: begin
        put_text("PID"); put_dec(nid, 3);
      end
      REQ_READ_ID: put_text("PID");
      REQ_VERSION: put_text("PVER");
      REQ_BAUD: begin
        put_text("PBD"); put_dec(baud, (baud >= 10) ? 2 : 1);
      end
      default: put_text("PDebug");
    endcase
    frame_q.push_back('{ch: "!", last: 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t want;
    if (!rst_ni) begin
      frame_q.delete();
      fail_cnt_o   = 0;
      open_bytes_o = 0;
      frame_cnt_o  = 0;
      byte_cnt_o   = 0;
    end else begin
      if (tx_i.valid && tx_i.ready) begin
        if (frame_q.size() == 0) begin
          $error("unexpected byte beat: tx_byte 0x%02h last_byte %0b",
                 tx_i.tx_byte, tx_i.last_byte);
          fail_cnt_o++;
        end else begin
          want = frame_q.pop_front();
          byte_cnt_o++;
          if (want.last) frame_cnt_o++;
          if (tx_i.tx_byte !== want.ch) begin
            $error("tx_byte: expected 0x%02h, actual 0x%02h", want.ch, tx_i.tx_byte);
            fail_cnt_o++;
          end
          if (tx_i.last_byte !== want.last) begin
            $error("last_byte: expected %0b, actual %0b", want.last, tx_i.last_byte);
            fail_cnt_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        queue_frame(req_kind_e'(req_i.req_type), req_i.motor_id, req_i.pwm_value,
                    req_i.time_value, req_i.lin_speed, req_i.new_id, req_i.baud_sel);
      end
      open_bytes_o = frame_q.size();
    end
  end

endmodule

### sim/servo_ascii_command_framer_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for servo_ascii_command_framer_core: clock, reset, request and
// byte-side stimulus, verdict. Depends on sacf_pkg, both channel interfaces,
// the core and servo_ascii_command_framer_core_checker.
module servo_ascii_command_framer_core_tb;
  import sacf_pkg::*;

  localparam int unsigned RandCmds    = 347;
  localparam int unsigned IdlePct     = 23;
  // Both sides run without idling while the accepted count is in this window.
  localparam int unsigned QuietLo     = 180;
  localparam int unsigned QuietHi     = 250;
  // Long hold-off on the byte side, started once this many beats are in.
  localparam int unsigned StallAt     = 60;
  localparam int unsigned StallLen    = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 100000;

  typedef struct {
    req_kind_e          kind;
    logic [7:0]         id;
    logic [13:0]        pwm;
    logic [15:0]        tim;
    logic signed [15:0] spd;
    logic [7:0]         nid;
    logic [3:0]         baud;
  } servo_cmd_t;

  logic clk_i;
  logic rst_ni;
  int   sent_cnt;
  int   directed_cnt;
  int   cycle_cnt;
  int   fail_cnt;
  int   open_bytes;
  int   frame_cnt;
  int   byte_cnt;
  logic quiet;

  sacf_req_if  req_ch ();
  sacf_byte_if tx_ch ();

  servo_ascii_command_framer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .tx_o   (tx_ch)
  );

  servo_ascii_command_framer_core_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .tx_i         (tx_ch),
    .fail_cnt_o   (fail_cnt),
    .open_bytes_o (open_bytes),
    .frame_cnt_o  (frame_cnt),
    .byte_cnt_o   (byte_cnt)
  );

  assign quiet = (sent_cnt >= QuietLo) && (sent_cnt < QuietHi);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one request beat. Idle a random number of cycles first (with junk on
  // the payload so that only valid qualifies it), then hold the beat until the
  // block takes it. The ready sampled right after the edge is the one the edge
  // saw, since every driver updates through nonblocking assignments.
  task automatic offer_cmd(input servo_cmd_t c);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 3'($urandom);
      req_ch.motor_id   <= 8'($urandom);
      req_ch.pwm_value  <= 14'($urandom);
      req_ch.time_value <= 16'($urandom);
      req_ch.lin_speed  <= 16'($urandom);
      req_ch.new_id     <= 8'($urandom);
      req_ch.baud_sel   <= 4'($urandom);
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= c.kind;
    req_ch.motor_id   <= c.id;
    req_ch.pwm_value  <= c.pwm;
    req_ch.time_value <= c.tim;
    req_ch.lin_speed  <= c.spd;
    req_ch.new_id     <= c.nid;
    req_ch.baud_sel   <= c.baud;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic offer(input req_kind_e kind, input int id, input int pwm, input int tim,
                       input int spd, input int nid, input int baud);
    servo_cmd_t c;
    c.kind = kind;
    c.id   = 8'(id);
    c.pwm  = 14'(pwm);
    c.tim  = 16'(tim);
    c.spd  = 16'(spd);
    c.nid  = 8'(nid);
    c.baud = 4'(baud);
    offer_cmd(c);
  endtask

  // Random request: every kind, full-width fields, but most numbers kept in
  // the ranges where the interesting digits and the unclamped speed live.
  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    c.kind = req_kind_e'($urandom_range(7));
    c.id   = 8'($urandom);
    c.nid  = 8'($urandom);
    c.pwm  = ($urandom_range(99) < 80) ? 14'($urandom_range(9999)) : 14'($urandom);
    if (c.kind == REQ_SPEED || $urandom_range(99) < 30) c.tim = 16'($urandom);
    else c.tim = 16'($urandom_range(9999));
    if ($urandom_range(99) < 60) c.spd = 16'(int'($urandom_range(3000)) - 1500);
    else c.spd = 16'($urandom);
    c.baud = ($urandom_range(99) < 70) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10));
    return c;
  endfunction

  // Request side: directed corners, then the random bulk, then drain and verdict.
  initial begin
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_OPEN;
    req_ch.motor_id   <= '0;
    req_ch.pwm_value  <= '0;
    req_ch.time_value <= '0;
    req_ch.lin_speed  <= '0;
    req_ch.new_id     <= '0;
    req_ch.baud_sel   <= '0;
    sent_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Open and closed loop: all-zero and all-nine digits, saturation just
    // past 9999 and at the field maximum.
    offer(REQ_OPEN,     0,     0,     0,      0,   0,  0);
    offer(REQ_OPEN,   255,  9999,  9999,      0,   0,  0);
    offer(REQ_OPEN,   123, 10000, 10000,      0,   0,  0);
    offer(REQ_CLOSED,   7, 16383, 65535,      0,   0,  0);
    offer(REQ_CLOSED,  42,  1500,  1234,      0,   0,  0);
    // Speed mode: rest, both clamps, the exact-division edges on either
    // side, a small negative speed that floors away from zero, and the
    // millisecond-to-second division at its edges.
    offer(REQ_SPEED,    1,     0,     0,      0,   0,  0);
    offer(REQ_SPEED,   99,     0, 65535,  32767,   0,  0);
    offer(REQ_SPEED,  200,     0,   999, -32768,   0,  0);
    offer(REQ_SPEED,   10,     0,  1000,    805,   0,  0);
    offer(REQ_SPEED,   11,     0,  1999,    806,   0,  0);
    offer(REQ_SPEED,   12,     0,  2000,    807,   0,  0);
    offer(REQ_SPEED,   13,     0,  9999,   -773,   0,  0);
    offer(REQ_SPEED,   14,     0, 10000,   -806,   0,  0);
    offer(REQ_SPEED,   15,     0,  5432,     -1,   0,  0);
    // Id, version and debug bodies.
    offer(REQ_SET_ID, 255,     0,     0,      0,   0,  0);
    offer(REQ_SET_ID,   0,     0,     0,      0, 255,  0);
    offer(REQ_READ_ID, 64,     0,     0,      0,   0,  0);
    offer(REQ_VERSION, 128,    0,     0,      0,   0,  0);
    offer(REQ_DEBUG,    3,     0,     0,      0,   0,  0);
    // Baud digit, including the two-digit indexes past nine.
    offer(REQ_BAUD,     5,     0,     0,      0,   0,  0);
    offer(REQ_BAUD,     5,     0,     0,      0,   0,  9);
    offer(REQ_BAUD,     5,     0,     0,      0,   0, 10);
    offer(REQ_BAUD,     5,     0,     0,      0,   0, 15);
    directed_cnt = sent_cnt;

    for (int i = 0; i < RandCmds; i++) offer_cmd(random_cmd());
    req_ch.valid <= 1'b0;

    // Wait out the bytes still owed, then give the pipeline time to show
    // any stray beat.
    @(posedge clk_i);
    while (open_bytes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d requests (%0d directed corners, all eight kinds), %0d frames / %0d bytes",
             sent_cnt, directed_cnt, frame_cnt, byte_cnt);
    $display("tb: random idling on both sides, one %0d-cycle byte-side hold-off", StallLen);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Byte side: random ready, no idling in the quiet window, and one long
  // hold-off counted here so the chain and pipeline back up into req_i.
  initial begin
    int  hold_left;
    bit  stall_done;
    hold_left  = 0;
    stall_done = 1'b0;
    tx_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!stall_done && sent_cnt >= StallAt) begin
        hold_left  = StallLen;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        tx_ch.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        tx_ch.ready <= 1'b1;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: end the run if the stimulus or the drain never completes.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: watchdog expired after %0d cycles, %0d bytes still owed",
             cycle_cnt, open_bytes);
    $display("tb: failure");
    $finish;
  end

endmodule
